>>> rtl/utf8_sequence_decoder_top_assert.svh
// Assertion macros shared by the checker.
`ifndef UTF8_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define UTF8_SEQUENCE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8sd implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8sd next-cycle check failed");

`endif

>>> rtl/utf8sd_pkg.sv
`default_nettype none

package utf8sd_pkg;

  localparam logic [7:0]  LEAD_MIN    = 8'hC0;
  localparam logic [1:0]  CONT_TAG    = 2'b10;
  localparam logic [30:0] REPL_CHAR   = 31'h0000_FFFD;
  localparam logic [2:0]  WINDOW_MAX  = 3'd6;
  localparam logic [2:0]  AVAIL_SAT   = 3'd7;
  localparam logic [2:0]  LEN_ONE     = 3'd1;

  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [7:0] byte_five;
    logic [2:0] available;
  } utf8sd_in_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  consumed;
  } utf8sd_out_t;

endpackage

`default_nettype wire

>>> rtl/utf8_sequence_decoder_top.sv
// channel | direction | handshake            | word
// --------+-----------+----------------------+-----------------------------
// input   | in        | start_i, busy_o      | in_word_i  (utf8sd_in_t)
// result  | out       | done_o (one cycle)   | res_word_o (utf8sd_out_t)
//
// One word accepted per cycle; busy_o stays low.
// done_o rises after the accepted word has passed the input register and the result register.
// Path: input register, decode, result register.
// rst_ni clears the valid flags of both registers asynchronously.
// The receiver cannot stall; done_o is a one-cycle strobe.
`default_nettype none

module utf8_sequence_decoder_top #(
  parameter int unsigned MAX_SEQ_BYTES = 6
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire utf8sd_pkg::utf8sd_in_t  in_word_i,
  output logic                         done_o,
  output utf8sd_pkg::utf8sd_out_t      res_word_o
);

  utf8sd_pkg::utf8sd_in_t  in_q;
  logic                    vld_q;
  utf8sd_pkg::utf8sd_out_t res_d;
  utf8sd_pkg::utf8sd_out_t res_q;
  logic                    done_q;
  logic                    accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= accept;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  utf8sd_decode #(
    .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
  ) u_decode (
    .word_i (in_q),
    .word_o (res_d)
  );

  assign done_o     = done_q;
  assign res_word_o = res_q;

endmodule

`default_nettype wire

>>> rtl/utf8sd_decode.sv
`default_nettype none

module utf8sd_decode #(
  parameter int unsigned MAX_SEQ_BYTES = 6
) (
  input  wire utf8sd_pkg::utf8sd_in_t word_i,
  output utf8sd_pkg::utf8sd_out_t     word_o
);

  logic [3:0]  seq_len;
  logic        plain;
  logic [2:0]  avail_sat;
  logic [7:0]  cont [1:5];
  logic        bad_cont;
  logic [30:0] value;

  assign cont[1] = word_i.byte_one;
  assign cont[2] = word_i.byte_two;
  assign cont[3] = word_i.byte_three;
  assign cont[4] = word_i.byte_four;
  assign cont[5] = word_i.byte_five;

  assign plain     = word_i.lead_byte < utf8sd_pkg::LEAD_MIN;
  assign avail_sat = (word_i.available == utf8sd_pkg::AVAIL_SAT) ?
                     utf8sd_pkg::WINDOW_MAX : word_i.available;

  // declared length from the run of ones in the lead byte
  always_comb begin
    unique casez (word_i.lead_byte)
      8'b110?_????: seq_len = 4'd2;
      8'b1110_????: seq_len = 4'd3;
      8'b1111_0???: seq_len = 4'd4;
      8'b1111_10??: seq_len = 4'd5;
      8'b1111_110?: seq_len = 4'd6;
      8'b1111_1110: seq_len = 4'd7;
      8'b1111_1111: seq_len = 4'd8;
      default:      seq_len = 4'd1;
    endcase
  end

  always_comb begin
    bad_cont = 1'b0;
    for (int k = 1; k <= 5; k++) begin
      if ((4'(k) < seq_len) && (cont[k][7:6] != utf8sd_pkg::CONT_TAG)) begin
        bad_cont = 1'b1;
      end
    end
  end

  always_comb begin
    case (seq_len)
      4'd2: value = 31'({word_i.lead_byte[4:0], cont[1][5:0]});
      4'd3: value = 31'({word_i.lead_byte[3:0], cont[1][5:0], cont[2][5:0]});
      4'd4: value = 31'({word_i.lead_byte[2:0], cont[1][5:0], cont[2][5:0],
                         cont[3][5:0]});
      4'd5: value = 31'({word_i.lead_byte[1:0], cont[1][5:0], cont[2][5:0],
                         cont[3][5:0], cont[4][5:0]});
      4'd6: value = {word_i.lead_byte[0], cont[1][5:0], cont[2][5:0],
                     cont[3][5:0], cont[4][5:0], cont[5][5:0]};
      default: value = 31'(word_i.lead_byte);
    endcase
  end

  always_comb begin
    word_o.code_point = 31'(word_i.lead_byte);
    word_o.consumed   = utf8sd_pkg::LEN_ONE;
    if (!plain && (seq_len <= 4'(MAX_SEQ_BYTES))) begin
      if (seq_len > {1'b0, avail_sat}) begin
        word_o.code_point = utf8sd_pkg::REPL_CHAR;
      end else if (!bad_cont) begin
        word_o.code_point = value;
        word_o.consumed   = seq_len[2:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/utf8sd_checker.sv
`default_nettype none

`include "utf8_sequence_decoder_top_assert.svh"

module utf8sd_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          start_i,
  input wire                          busy_o,
  input wire                          done_o,
  input wire utf8sd_pkg::utf8sd_out_t res_word_o
);

  logic acc;
  logic fallback;
  logic len_ok;
  logic fb_ok;

  assign acc      = start_i && !busy_o;
  assign fallback = done_o && (res_word_o.consumed == utf8sd_pkg::LEN_ONE);
  assign len_ok   = (res_word_o.consumed != 3'd0) &&
                    (res_word_o.consumed != utf8sd_pkg::AVAIL_SAT);
  assign fb_ok    = (res_word_o.code_point[30:8] == 23'd0) ||
                    (res_word_o.code_point == utf8sd_pkg::REPL_CHAR);

  `U8SD_ASSERT_NEXT(a_acc_gives_result, clk_i, rst_ni, acc, ##1 done_o)
  `U8SD_ASSERT_IMPL(a_result_had_word, clk_i, rst_ni, done_o, $past(acc, 2))
  `U8SD_ASSERT_IMPL(a_len_range, clk_i, rst_ni, done_o, len_ok)
  `U8SD_ASSERT_IMPL(a_fallback_value, clk_i, rst_ni, fallback, fb_ok)

endmodule

bind utf8_sequence_decoder_top utf8sd_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .res_word_o (res_word_o)
);

`default_nettype wire
